// ===== rtl/rkc_pkg.sv =====
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared constants and types of the 3x3 RGB convolution filter.
// ----------------------------------------------------------------------------
package rkc_pkg;

   localparam int MAX_LINE_WIDTH = 1024;
   localparam int KERNEL_DIM     = 3;
   localparam int TAPS           = KERNEL_DIM * KERNEL_DIM;
   localparam int LINE_AW        = $clog2(MAX_LINE_WIDTH);
   localparam int W_CAP          = (MAX_LINE_WIDTH < 1024) ? MAX_LINE_WIDTH : 1024;
   localparam int HEIGHT_CAP     = 4096;
   localparam int PIX_MAX        = 255;
   localparam int SUM_W          = 28;
   localparam int ROUND_HALF     = 2048;
   localparam int FRAC_BITS      = 12;

   // register indexes
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_COEF_WORD_0  = 3'd2;
   localparam logic [2:0] REG_COEF_WORD_1  = 3'd3;
   localparam logic [2:0] REG_COEF_WORD_2  = 3'd4;

   // one output pixel travelling down the tap chain
   typedef struct packed {
      logic [TAPS-1:0][23:0]  pix;
      logic [7:0]             alpha;
      logic [9:0]             col;
      logic [11:0]            row;
      logic                   last;
      logic                   done;
      logic [2:0][SUM_W-1:0]  sum;
   } conv_type;

   // window snapshot handed to the emission sequencer
   typedef struct packed {
      logic [TAPS-1:0][31:0]  win;
      logic [9:0]             col;
      logic [11:0]            row;
      logic                   row_is1;
      logic                   col_is1;
      logic [3:0]             mask;
   } snap_type;

endpackage

// ===== rtl/rgb_kernel_convolution_clamped_edges.sv =====
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_clamped_edges
// 3x3 RGB convolution of a raster pixel stream with clamp-to-edge borders.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid / req_stall  req_in_red/green/blue/alpha
//  rsp       out        rsp_valid / rsp_stall  rsp_out_*, rsp_last_of_run, ...
//  csr       in         APB psel/penable       paddr (8-byte stride), pwdata
//
//  One pixel a cycle where it causes at most one output and the output is not
//  stalled; a pixel at the last column or row holds the input until all its
//  outputs (up to 4) are issued. The rate is set by the emission sequencer,
//  which issues one output pixel a cycle, unless the output stalls, into a
//  chain of nine registered tap cells that feed the rsp_valid output register.
//  Reset clears the window, counters and pipeline valids; the line buffers
//  are not cleared. A stalled output freezes the whole chain.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution_clamped_edges (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic [7:0]  req_in_alpha,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_alpha,
   output logic [9:0]  rsp_out_col,
   output logic [11:0] rsp_out_row,
   output logic        rsp_last_of_run,
   output logic        rsp_frame_done,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import rkc_pkg::*;

   // configuration
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [63:0] coef0_ff, coef1_ff;
   logic [15:0] coef2_ff;
   logic        cfg_wr;
   logic [2:0]  cfg_idx;

   assign pready  = 1'b1;
   assign cfg_idx = paddr[5:3];
   assign cfg_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 13'd480;
         coef0_ff  <= '0;
         coef1_ff  <= '0;
         coef2_ff  <= '0;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[10:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[12:0];
            REG_COEF_WORD_0:  coef0_ff  <= pwdata;
            REG_COEF_WORD_1:  coef1_ff  <= pwdata;
            REG_COEF_WORD_2:  coef2_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_IMAGE_WIDTH:  prdata = {53'd0, width_ff};
         REG_IMAGE_HEIGHT: prdata = {51'd0, height_ff};
         REG_COEF_WORD_0:  prdata = coef0_ff;
         REG_COEF_WORD_1:  prdata = coef1_ff;
         REG_COEF_WORD_2:  prdata = {48'd0, coef2_ff};
         default:          prdata = '0;
      endcase
   end

   logic [TAPS-1:0][15:0] taps;
   assign taps = {coef2_ff, coef1_ff, coef0_ff};

   // geometry
   logic [10:0] w_eff, wm1;
   logic [12:0] h_eff, hm1;
   logic        last_col, last_row;
   logic [9:0]  col_ff, col_in;
   logic [11:0] row_ff, row_in;
   logic        accept;

   always_comb begin
      if (width_ff < 11'd2)              w_eff = 11'd2;
      else if (width_ff > 11'(W_CAP))    w_eff = 11'(W_CAP);
      else                               w_eff = width_ff;
      if (height_ff < 13'd2)             h_eff = 13'd2;
      else if (height_ff > 13'(HEIGHT_CAP)) h_eff = 13'(HEIGHT_CAP);
      else                               h_eff = height_ff;
      wm1      = w_eff - 11'd1;
      hm1      = h_eff - 13'd1;
      last_col = {1'b0, col_ff} >= wm1;
      last_row = {1'b0, row_ff} >= hm1;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = 10'd0;
            row_in = last_row ? 12'd0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // front stage: line buffer read in flight
   logic        f1v_ff, f1_go, seq_free, adv;
   logic [31:0] f1_px_ff;
   logic [9:0]  f1_col_ff;
   logic [11:0] f1_row_ff;
   logic        f1_lc_ff, f1_lr_ff;
   logic [63:0] line_q;
   logic [TAPS-1:0][31:0] win_ff, win_in;
   snap_type    snap;

   assign f1_go     = f1v_ff && seq_free;
   assign req_stall = f1v_ff && !f1_go;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1v_ff <= 1'b0;
      end else if (accept) begin
         f1v_ff <= 1'b1;
      end else if (f1_go) begin
         f1v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_px_ff  <= {req_in_alpha, req_in_blue, req_in_green, req_in_red};
         f1_col_ff <= col_ff;
         f1_row_ff <= row_ff;
         f1_lc_ff  <= last_col;
         f1_lr_ff  <= last_row;
      end
   end

   rkc_line_mem u_line_mem (
      .clock      (clock),
      .wr_en      (f1_go),
      .wr_addr    (LINE_AW'(f1_col_ff)),
      .wr_data    ({line_q[31:0], f1_px_ff}),
      .rd_en      (accept),
      .rd_addr    (LINE_AW'(col_ff)),
      .rd_data_ff (line_q)
   );

   always_comb begin
      win_in = win_ff;
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = line_q[63:32];
      win_in[5] = line_q[31:0];
      win_in[8] = f1_px_ff;
      snap.win     = win_in;
      snap.col     = f1_col_ff;
      snap.row     = f1_row_ff;
      snap.row_is1 = (f1_row_ff == 12'd1);
      snap.col_is1 = (f1_col_ff == 10'd1);
      snap.mask[0] = (f1_row_ff != 12'd0) && (f1_col_ff != 10'd0);
      snap.mask[1] = (f1_row_ff != 12'd0) && f1_lc_ff;
      snap.mask[2] = f1_lr_ff && (f1_col_ff != 10'd0);
      snap.mask[3] = f1_lr_ff && f1_lc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (f1_go) begin
         win_ff <= win_in;
      end
   end

   // emission sequencer and tap chain
   logic     v [TAPS+1];
   conv_type d [TAPS+1];

   rkc_emit_seq u_emit_seq (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .load        (f1_go),
      .load_data   (snap),
      .free        (seq_free),
      .issue_valid (v[0]),
      .issue_data  (d[0])
   );

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      rkc_tap_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .adv          (adv),
         .in_valid     (v[i]),
         .in_data      (d[i]),
         .pix          (d[i].pix[i]),
         .tap          (taps[i]),
         .out_valid_ff (v[i+1]),
         .out_data_ff  (d[i+1])
      );
   end

   // output register: round half away from zero, saturate
   logic       outv_ff;
   logic [7:0] chan [3];
   logic signed [SUM_W-1:0] s, q;

   assign adv = !outv_ff || !rsp_stall;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         s = $signed(d[TAPS].sum[ch]);
         q = (s + SUM_W'(ROUND_HALF)) >>> FRAC_BITS;
         if (s <= 0)                    chan[ch] = 8'd0;
         else if (q > SUM_W'(PIX_MAX))  chan[ch] = 8'(PIX_MAX);
         else                           chan[ch] = q[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outv_ff <= 1'b0;
      end else if (adv) begin
         outv_ff <= v[TAPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_out_red     <= chan[0];
         rsp_out_green   <= chan[1];
         rsp_out_blue    <= chan[2];
         rsp_out_alpha   <= d[TAPS].alpha;
         rsp_out_col     <= d[TAPS].col;
         rsp_out_row     <= d[TAPS].row;
         rsp_last_of_run <= d[TAPS].last;
         rsp_frame_done  <= d[TAPS].done;
      end
   end

   assign rsp_valid = outv_ff;

   a_accept_moves_front: assert property (@(posedge clock) disable iff (reset)
      (accept && f1v_ff) |-> f1_go)
      else $error("input taken while front stage blocked");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> rsp_last_of_run)
      else $error("frame end not last of its run");

   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(v[TAPS]) && $stable(d[1].col)))
      else $error("tap chain moved while output stalled");

endmodule

// ===== rtl/rkc_line_mem.sv =====
// ----------------------------------------------------------------------------
// rkc_line_mem
// Two line buffers in one word: upper line in the high half, lower in the low.
// ----------------------------------------------------------------------------
module rkc_line_mem (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [rkc_pkg::LINE_AW-1:0] wr_addr,
   input  logic [63:0]               wr_data,
   input  logic                      rd_en,
   input  logic [rkc_pkg::LINE_AW-1:0] rd_addr,
   output logic [63:0]               rd_data_ff
);
   import rkc_pkg::*;

   logic [63:0] mem_ff [MAX_LINE_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/rkc_tap_cell.sv =====
// ----------------------------------------------------------------------------
// rkc_tap_cell
// One kernel tap: multiply one pixel by the tap and add to the running sums.
// ----------------------------------------------------------------------------
module rkc_tap_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  rkc_pkg::conv_type in_data,
   input  logic [23:0]       pix,
   input  logic [15:0]       tap,
   output logic              out_valid_ff,
   output rkc_pkg::conv_type out_data_ff
);
   import rkc_pkg::*;

   logic signed [24:0] prod [3];
   conv_type           data_in;

   always_comb begin
      data_in = in_data;
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = $signed({1'b0, pix[ch*8 +: 8]}) * $signed(tap);
         data_in.sum[ch] = SUM_W'($signed(in_data.sum[ch]) + SUM_W'(prod[ch]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/rkc_emit_seq.sv =====
// ----------------------------------------------------------------------------
// rkc_emit_seq
// Holds a snapshot and issues its pending output pixels, one a cycle on adv.
// ----------------------------------------------------------------------------
module rkc_emit_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              load,
   input  rkc_pkg::snap_type load_data,
   output logic              free,
   output logic              issue_valid,
   output rkc_pkg::conv_type issue_data
);
   import rkc_pkg::*;

   logic [3:0] pend_ff, pend_in;
   snap_type   snap_ff;
   logic [3:0] lowbit, rem;
   logic       rs_b, cs_b;
   logic [1:0] rs [3];
   logic [1:0] cs [3];
   logic [31:0] sel;

   always_comb begin
      lowbit = pend_ff & (~pend_ff + 4'd1);
      rem    = pend_ff & ~lowbit;
      free   = (pend_ff == 4'd0) || (adv && rem == 4'd0);
      rs_b   = lowbit[2] | lowbit[3];
      cs_b   = lowbit[1] | lowbit[3];
      // rows or columns clamp at the edges of the frame
      rs[0] = rs_b ? 2'd1 : (snap_ff.row_is1 ? 2'd1 : 2'd0);
      rs[1] = rs_b ? 2'd2 : 2'd1;
      rs[2] = 2'd2;
      cs[0] = cs_b ? 2'd1 : (snap_ff.col_is1 ? 2'd1 : 2'd0);
      cs[1] = cs_b ? 2'd2 : 2'd1;
      cs[2] = 2'd2;
      issue_data = '0;
      for (int kr = 0; kr < 3; kr++) begin
         for (int kc = 0; kc < 3; kc++) begin
            sel = snap_ff.win[rs[kr]*3 + cs[kc]];
            issue_data.pix[kr*3 + kc] = sel[23:0];
         end
      end
      sel = snap_ff.win[rs[1]*3 + cs[1]];
      issue_data.alpha = sel[31:24];
      issue_data.row   = rs_b ? snap_ff.row : snap_ff.row - 12'd1;
      issue_data.col   = cs_b ? snap_ff.col : snap_ff.col - 10'd1;
      issue_data.last  = (rem == 4'd0);
      issue_data.done  = lowbit[3];
      issue_valid      = (pend_ff != 4'd0);
   end

   always_comb begin
      pend_in = pend_ff;
      if (load) begin
         pend_in = load_data.mask;
      end else if (adv) begin
         pend_in = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 4'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         snap_ff <= load_data;
      end
   end

endmodule
